// ===== rtl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared types, codes and fixed widths of the mixer datapath.
// ----------------------------------------------------------------------------
package mwm_pkg;

   // Fixed widths of the register and result fields.
   localparam int CFG_W      = 15;
   localparam int SPEED_W    = 16;
   localparam int NUM_WHEELS = 4;

   // Bit-serial multiply and divide both run over the width of the scale.
   localparam int SPAN_W = CFG_W;
   localparam int CNT_W  = 4;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPAN_W - 1);

   // Register port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam logic [CFG_W-1:0] MAX_OUTPUT_RESET = 15'd25600;

   // Wheel lanes.
   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_BL = 2;
   localparam int WHEEL_BR = 3;

   // Kind of write carried by a result item.
   localparam int KIND_W = 2;
   typedef enum logic [KIND_W-1:0] {
      KIND_SPEEDS = 2'd0,
      KIND_STOP   = 2'd1,
      KIND_NONE   = 2'd2
   } kind_type;

   // Register indexes.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_MAX_OUTPUT = 3'd0,
      REG_FRICTION_FL = 3'd1,
      REG_FRICTION_FR = 3'd2,
      REG_FRICTION_BL = 3'd3,
      REG_FRICTION_BR = 3'd4
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // Strobes from the sequencer to the wheel lanes.
   typedef struct packed {
      logic load;
      logic mul_step;
      logic div_step;
      logic span_bit;
   } lane_ctrl_type;

endpackage

// ===== rtl/mwm_req_if.sv =====
// ----------------------------------------------------------------------------
// Mixer command channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface mwm_req_if #(
   parameter int CMD_WIDTH = 16
) ();

   logic                        valid;
   logic                        ready;
   logic signed [CMD_WIDTH-1:0] strafe_cmd;
   logic signed [CMD_WIDTH-1:0] forward_cmd;
   logic signed [CMD_WIDTH-1:0] turn_cmd;
   logic                        drive_enabled;

   modport source (
      output valid, strafe_cmd, forward_cmd, turn_cmd, drive_enabled,
      input  ready
   );

   modport sink (
      input  valid, strafe_cmd, forward_cmd, turn_cmd, drive_enabled,
      output ready
   );

endinterface

// ===== rtl/mwm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Mixer result channel
// Valid/ready channel that carries one wheel speed item.
// ----------------------------------------------------------------------------
interface mwm_rsp_if
   import mwm_pkg::*;
();

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         write_kind;
   logic signed [SPEED_W-1:0] speed_front_left;
   logic signed [SPEED_W-1:0] speed_front_right;
   logic signed [SPEED_W-1:0] speed_back_left;
   logic signed [SPEED_W-1:0] speed_back_right;

   modport source (
      output valid, write_kind, speed_front_left, speed_front_right,
             speed_back_left, speed_back_right,
      input  ready
   );

   modport sink (
      input  valid, write_kind, speed_front_left, speed_front_right,
             speed_back_left, speed_back_right,
      output ready
   );

endinterface

// ===== rtl/mecanum_wheel_mixer_unit.sv =====
// Sequence: an enabled item is taken in idle, then passes through
// (1 setup, 15 multiply steps, 15 divide steps, 1 output load); the load waits for a free output slot.
// A new item is taken only in idle, after the last one is loaded out; each of the four wheel
// lanes has its own bit-serial multiply and divide. A disabled item skips to the output load.
// Reset: synchronous; restores the register defaults and marks motors stopped.
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Mixes strafe, forward and turn commands into four wheel percents.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_unit
   import mwm_pkg::*;
#(
   parameter int CMD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   mwm_req_if.sink               req_ch,
   mwm_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int A_W  = CMD_WIDTH + 1;
   localparam int DV_W = A_W + SPAN_W - 1;

   logic [CFG_W-1:0]          max_output;
   logic [CFG_W-1:0]          friction [NUM_WHEELS];
   lane_ctrl_type             lane_ctl;
   logic [A_W-1:0]            w_abs [NUM_WHEELS];
   logic                      w_neg [NUM_WHEELS];
   logic [DV_W-1:0]           divisor;
   logic                      emit;
   kind_type                  kind;
   logic                      slot_free;
   logic signed [SPEED_W-1:0] lane_speed [NUM_WHEELS];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff [NUM_WHEELS];
   logic signed [SPEED_W-1:0] rsp_speed_in [NUM_WHEELS];

   mwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_output  (max_output),
      .friction    (friction)
   );

   mwm_ctrl #(.CMD_WIDTH(CMD_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .max_output (max_output),
      .friction   (friction),
      .slot_free  (slot_free),
      .lane_ctl   (lane_ctl),
      .w_abs      (w_abs),
      .w_neg      (w_neg),
      .divisor    (divisor),
      .emit       (emit),
      .kind       (kind)
   );

   // One lane per wheel, all stepped together.
   for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
      mwm_lane #(.CMD_WIDTH(CMD_WIDTH)) u_lane (
         .clock      (clock),
         .lane_ctl   (lane_ctl),
         .w_abs      (w_abs[g]),
         .w_neg      (w_neg[g]),
         .divisor    (divisor),
         .friction   (friction[g]),
         .max_output (max_output),
         .speed      (lane_speed[g])
      );
   end

   // Output register; it frees as the waiting item is taken.
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         rsp_speed_in[i] = rsp_speed_ff[i];
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            rsp_speed_in[i] = (kind == KIND_SPEEDS) ? lane_speed[i] : '0;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         rsp_speed_ff[i] <= rsp_speed_in[i];
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.write_kind        = rsp_kind_ff;
   assign rsp_ch.speed_front_left  = rsp_speed_ff[WHEEL_FL];
   assign rsp_ch.speed_front_right = rsp_speed_ff[WHEEL_FR];
   assign rsp_ch.speed_back_left   = rsp_speed_ff[WHEEL_BL];
   assign rsp_ch.speed_back_right  = rsp_speed_ff[WHEEL_BR];

endmodule

// ===== rtl/mwm_csr.sv =====
// ----------------------------------------------------------------------------
// Mixer register file
// APB-style registers for the output limit and the four friction offsets.
// ----------------------------------------------------------------------------
module mwm_csr
   import mwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      max_output,
   output logic [CFG_W-1:0]      friction [NUM_WHEELS]
);

   logic [CFG_W-1:0] max_output_ff, max_output_in;
   logic [CFG_W-1:0] friction_ff [NUM_WHEELS];
   logic [CFG_W-1:0] friction_in [NUM_WHEELS];
   reg_index_type    reg_index;
   logic             wr_en;
   logic [CFG_W-1:0] rd_value;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Write decode; writes past the last register are dropped.
   always_comb begin
      max_output_in = max_output_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         friction_in[i] = friction_ff[i];
      end
      if (wr_en) begin
         unique case (reg_index)
            REG_MAX_OUTPUT:  max_output_in = csr_pwdata[CFG_W-1:0];
            REG_FRICTION_FL: friction_in[WHEEL_FL] = csr_pwdata[CFG_W-1:0];
            REG_FRICTION_FR: friction_in[WHEEL_FR] = csr_pwdata[CFG_W-1:0];
            REG_FRICTION_BL: friction_in[WHEEL_BL] = csr_pwdata[CFG_W-1:0];
            REG_FRICTION_BR: friction_in[WHEEL_BR] = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_output_ff <= MAX_OUTPUT_RESET;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            friction_ff[i] <= '0;
         end
      end else begin
         max_output_ff <= max_output_in;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            friction_ff[i] <= friction_in[i];
         end
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         REG_MAX_OUTPUT:  rd_value = max_output_ff;
         REG_FRICTION_FL: rd_value = friction_ff[WHEEL_FL];
         REG_FRICTION_FR: rd_value = friction_ff[WHEEL_FR];
         REG_FRICTION_BL: rd_value = friction_ff[WHEEL_BL];
         REG_FRICTION_BR: rd_value = friction_ff[WHEEL_BR];
         default:         rd_value = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, rd_value};
   assign max_output = max_output_ff;
   assign friction   = friction_ff;

endmodule

// ===== rtl/mwm_lane.sv =====
// ----------------------------------------------------------------------------
// Mixer wheel lane
// Bit-serial multiply of one wheel magnitude by the scale, bit-serial
// restoring divide by the largest magnitude, then friction and clamp.
// ----------------------------------------------------------------------------
module mwm_lane
   import mwm_pkg::*;
#(
   parameter  int CMD_WIDTH = 16,
   localparam int A_W       = CMD_WIDTH + 1,
   localparam int ACC_W     = A_W + SPAN_W,
   localparam int DV_W      = A_W + SPAN_W - 1
) (
   input  logic                      clock,
   input  lane_ctrl_type             lane_ctl,
   input  logic [A_W-1:0]            w_abs,
   input  logic                      w_neg,
   input  logic [DV_W-1:0]           divisor,
   input  logic [CFG_W-1:0]          friction,
   input  logic [CFG_W-1:0]          max_output,
   output logic signed [SPEED_W-1:0] speed
);

   logic [A_W-1:0]     a_ff, a_in;
   logic               neg_ff, neg_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SPAN_W-1:0]  q_ff, q_in;
   logic [ACC_W-1:0]   addend;
   logic [ACC_W-1:0]   divisor_ext;
   logic [ACC_W-1:0]   diff;
   logic               fits;
   logic [SPEED_W-1:0] boosted;
   logic [SPEED_W-1:0] limit_ext;
   logic [SPEED_W-1:0] magnitude;

   // The accumulator holds the product during the multiply and the
   // remainder during the divide.
   assign addend      = lane_ctl.span_bit ? {{SPAN_W{1'b0}}, a_ff} : '0;
   assign divisor_ext = {1'b0, divisor};
   assign diff        = acc_ff - divisor_ext;
   assign fits        = acc_ff >= divisor_ext;

   always_comb begin
      a_in   = a_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      q_in   = q_ff;
      priority if (lane_ctl.load) begin
         a_in   = w_abs;
         neg_in = w_neg;
         acc_in = '0;
         q_in   = '0;
      end else if (lane_ctl.mul_step) begin
         acc_in = {acc_ff[ACC_W-2:0], 1'b0} + addend;
      end else if (lane_ctl.div_step) begin
         if (fits) begin
            acc_in = diff;
         end
         q_in = {q_ff[SPAN_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
   end

   // A nonzero quotient gets the wheel's friction added away from zero,
   // then the result is held to the output limit.
   assign boosted   = {1'b0, q_ff} + {1'b0, friction};
   assign limit_ext = {1'b0, max_output};

   always_comb begin
      if (q_ff == '0) begin
         magnitude = '0;
      end else if (boosted > limit_ext) begin
         magnitude = limit_ext;
      end else begin
         magnitude = boosted;
      end
   end

   assign speed = neg_ff ? $signed(-magnitude) : $signed(magnitude);

endmodule

// ===== rtl/mwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mixer sequencer
// Takes command items, forms the wheel sums, the divisor and the scale, and
// steps the wheel lanes through the serial multiply and divide.
// ----------------------------------------------------------------------------
module mwm_ctrl
   import mwm_pkg::*;
#(
   parameter  int CMD_WIDTH = 16,
   localparam int A_W       = CMD_WIDTH + 1,
   localparam int SUM_W     = CMD_WIDTH + 2,
   localparam int DV_W      = A_W + SPAN_W - 1
) (
   input  logic             clock,
   input  logic             reset,
   mwm_req_if.sink          req_ch,
   input  logic [CFG_W-1:0] max_output,
   input  logic [CFG_W-1:0] friction [NUM_WHEELS],
   input  logic             slot_free,
   output lane_ctrl_type    lane_ctl,
   output logic [A_W-1:0]   w_abs [NUM_WHEELS],
   output logic             w_neg [NUM_WHEELS],
   output logic [DV_W-1:0]  divisor,
   output logic             emit,
   output kind_type         kind
);

   localparam logic [A_W-1:0] ONE = {2'b01, {(CMD_WIDTH-1){1'b0}}};

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   stopped_ff, stopped_in;
   kind_type               kind_ff, kind_in;
   logic signed [SUM_W-1:0] w_ff [NUM_WHEELS];
   logic signed [SUM_W-1:0] w_in [NUM_WHEELS];
   logic signed [SUM_W-1:0] w_negated [NUM_WHEELS];
   logic signed [SUM_W-1:0] s_ext, f_ext, t_ext;
   logic [SPAN_W-1:0]      span_sh_ff, span_sh_in;
   logic [DV_W-1:0]        dv_ff, dv_in;
   logic [A_W-1:0]         mag;
   logic [CFG_W-1:0]       fric_max;
   logic [SPAN_W-1:0]      span;
   logic                   req_fire;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Wheel sums, formed as the item is taken.
   assign s_ext = SUM_W'(req_ch.strafe_cmd);
   assign f_ext = SUM_W'(req_ch.forward_cmd);
   assign t_ext = SUM_W'(req_ch.turn_cmd);

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         w_in[i] = w_ff[i];
      end
      if (req_fire) begin
         w_in[WHEEL_FL] = f_ext + s_ext + t_ext;
         w_in[WHEEL_FR] = f_ext - s_ext - t_ext;
         w_in[WHEEL_BL] = f_ext - s_ext + t_ext;
         w_in[WHEEL_BR] = f_ext + s_ext - t_ext;
      end
   end

   // Magnitude and direction of each wheel sum.
   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         w_negated[i] = -w_ff[i];
         w_neg[i]     = w_ff[i][SUM_W-1];
         w_abs[i]     = w_neg[i] ? w_negated[i][A_W-1:0] : w_ff[i][A_W-1:0];
      end
   end

   // Divisor is the largest magnitude, never below ONE (a full-scale command); the scale is the
   // limit less the largest friction among the moving wheels.
   always_comb begin
      mag      = ONE;
      fric_max = '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         if (w_abs[i] > mag) begin
            mag = w_abs[i];
         end
         if (w_abs[i] != '0 && friction[i] > fric_max) begin
            fric_max = friction[i];
         end
      end
      if (fric_max > max_output) begin
         fric_max = max_output;
      end
      span = max_output - fric_max;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      kind_in    = kind_ff;
      span_sh_in = span_sh_ff;
      dv_in      = dv_ff;
      lane_ctl   = '0;
      emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.drive_enabled) begin
                  kind_in    = KIND_SPEEDS;
                  stopped_in = 1'b0;
                  state_in   = ST_PREP;
               end else begin
                  kind_in    = stopped_ff ? KIND_NONE : KIND_STOP;
                  stopped_in = 1'b1;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_PREP: begin
            lane_ctl.load = 1'b1;
            span_sh_in    = span;
            dv_in         = {mag, {(SPAN_W-1){1'b0}}};
            cnt_in        = '0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            lane_ctl.mul_step = 1'b1;
            lane_ctl.span_bit = span_sh_ff[SPAN_W-1];
            span_sh_in        = {span_sh_ff[SPAN_W-2:0], 1'b0};
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            lane_ctl.div_step = 1'b1;
            dv_in             = dv_ff >> 1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         stopped_ff <= 1'b1;
         kind_ff    <= KIND_NONE;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         stopped_ff <= stopped_in;
         kind_ff    <= kind_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         w_ff[i] <= w_in[i];
      end
      span_sh_ff <= span_sh_in;
      dv_ff      <= dv_in;
   end

   assign divisor = dv_ff;
   assign kind    = kind_ff;

`ifndef SYNTH
   // A taken item always starts work.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("Accepted item did not leave idle.");

   // A disabled item goes straight to the result with the stop flag set.
   a_disabled_item: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_ch.drive_enabled) |=>
         (state_ff == ST_DONE && kind_ff != KIND_SPEEDS && stopped_ff))
      else $error("Disabled item handled wrongly.");

   // An enabled item writes speeds and clears the stop flag.
   a_enabled_item: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.drive_enabled) |=>
         (state_ff == ST_PREP && kind_ff == KIND_SPEEDS && !stopped_ff))
      else $error("Enabled item handled wrongly.");

   // The divide ends after its last step.
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> state_ff == ST_DONE)
      else $error("Divide did not finish on its last step.");
`endif

endmodule
